/* rtl/core/ldapesc_pkg.sv */
// ----------------------------------------------------------------------------
// ldapesc_pkg - shared types and constants of the LDAP string escaper
// Character codes, register indexes, queue entry and back-end state types.
// ----------------------------------------------------------------------------
package ldapesc_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MASK_LO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MASK_ML = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MASK_MH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MASK_HI = 3'd4;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOW_A = 8'h61;

	typedef struct packed {
		logic [7:0] data;
		logic       esc;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_HEAD,
		BK_HI,
		BK_LO
	} back_state_t;

	// lower-case hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CH_ZERO + {4'd0, nib};
		end else begin
			ch = CH_LOW_A + {4'd0, nib} - 8'd10;
		end
		return ch;
	endfunction

endpackage

/* rtl/core/ldapesc_front.sv */
// ----------------------------------------------------------------------------
// ldapesc_front - configuration registers and escape classification
// Holds mode and ignore mask, decides per accepted byte whether to escape.
// ----------------------------------------------------------------------------
module ldapesc_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [ldapesc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [ldapesc_pkg::CFG_DATA_W-1:0]   wr_data,
	input  logic [7:0]                           data_byte,
	input  logic                                 first_byte,
	input  logic                                 final_byte,
	output ldapesc_pkg::q_entry_t                entry
);
	import ldapesc_pkg::*;

	logic [1:0]   mode_q;
	logic [255:0] mask_q;
	logic         filt, dn, esc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			mask_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				CFG_ESCAPE_MODE:    mode_q         <= wr_data[1:0];
				CFG_IGNORE_MASK_LO: mask_q[63:0]   <= wr_data;
				CFG_IGNORE_MASK_ML: mask_q[127:64] <= wr_data;
				CFG_IGNORE_MASK_MH: mask_q[191:128] <= wr_data;
				CFG_IGNORE_MASK_HI: mask_q[255:192] <= wr_data;
				default: ;
			endcase
		end
	end

	assign filt = mode_q[0] || (mode_q == 2'd0);
	assign dn   = mode_q[1] || (mode_q == 2'd0);

	always_comb begin
		esc = 1'b0;
		if (filt && (data_byte inside {CH_STAR, CH_LPAR, CH_RPAR, CH_BSL})) begin
			esc = 1'b1;
		end
		if (dn && (data_byte inside {CH_BSL, CH_COMMA, CH_PLUS, CH_QUOTE,
				CH_LT, CH_GT, CH_SEMI})) begin
			esc = 1'b1;
		end
		if (dn && first_byte && (data_byte inside {CH_SPACE, CH_HASH})) begin
			esc = 1'b1;
		end
		if (dn && final_byte && (data_byte == CH_SPACE)) begin
			esc = 1'b1;
		end
		// ignore bit clears the decision, except for the zero byte
		if (mask_q[data_byte]) begin
			esc = 1'b0;
		end
		if (data_byte == CH_NUL) begin
			esc = 1'b1;
		end
	end

	assign entry.data = data_byte;
	assign entry.esc  = esc;

endmodule

/* rtl/core/ldapesc_queue.sv */
// ----------------------------------------------------------------------------
// ldapesc_queue - short register queue between front and back end
// Push and pop may happen in the same cycle; head is read at one pointer.
// ----------------------------------------------------------------------------
module ldapesc_queue #(
	parameter int DEPTH = ldapesc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ldapesc_pkg::q_entry_t push_entry,
	input  logic                  pop,
	output ldapesc_pkg::q_entry_t head,
	output ldapesc_pkg::q_status_t status
);
	import ldapesc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CW'(DEPTH));
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/ldapesc_back.sv */
// ----------------------------------------------------------------------------
// ldapesc_back - result sequencer
// Pops one queued byte and emits it raw, or as backslash and two hex digits.
// ----------------------------------------------------------------------------
module ldapesc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ldapesc_pkg::q_entry_t  head,
	input  ldapesc_pkg::q_status_t status,
	output logic                   pop,
	output logic                   strobe,
	output logic [7:0]             out_byte,
	output logic                   run_end
);
	import ldapesc_pkg::*;

	back_state_t state_q, state_d;
	logic [7:0]  hold_q;
	logic        emit;
	logic [7:0]  emit_byte;
	logic        emit_end;
	logic        strobe_q, run_end_q;
	logic [7:0]  out_byte_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_HEAD: begin
				if (!status.empty && head.esc) begin
					state_d = BK_HI;
				end
			end
			BK_HI:   state_d = BK_LO;
			BK_LO:   state_d = BK_HEAD;
			default: state_d = BK_HEAD;
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_byte = hold_q;
		emit_end  = 1'b0;
		case (state_q)
			BK_HEAD: begin
				pop  = !status.empty;
				emit = !status.empty;
				if (head.esc) begin
					emit_byte = CH_BSL;
				end else begin
					emit_byte = head.data;
					emit_end  = 1'b1;
				end
			end
			BK_HI: begin
				emit      = 1'b1;
				emit_byte = hex_digit(hold_q[7:4]);
			end
			BK_LO: begin
				emit      = 1'b1;
				emit_byte = hex_digit(hold_q[3:0]);
				emit_end  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_HEAD;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			hold_q <= head.data;
		end
		out_byte_q <= emit_byte;
		run_end_q  <= emit_end;
	end

	assign strobe   = strobe_q;
	assign out_byte = out_byte_q;
	assign run_end  = run_end_q;

endmodule

/* rtl/core/ldap_string_escaper.sv */
// ----------------------------------------------------------------------------
// ldap_string_escaper - LDAP filter / DN byte escaper
// Each plain byte gives one result and each escaped byte three; the back-end
// sequencer emits them through its output register at one result per cycle
// while it has work, so new bytes queue up behind an escaped one.
// Results cannot be stalled; busy rises only when the queue is full.
// Reset: asynchronous, active low; clears queue pointers, sequencer state and config registers.
// ----------------------------------------------------------------------------
module ldap_string_escaper #(
	parameter int QUEUE_DEPTH = ldapesc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               wr_en,
	input  logic [ldapesc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [ldapesc_pkg::CFG_DATA_W-1:0] wr_data,
	// command side
	input  logic                               start,
	output logic                               busy,
	input  logic [7:0]                         data_byte,
	input  logic                               first_byte,
	input  logic                               final_byte,
	// result side
	output logic                               strobe,
	output logic [7:0]                         out_byte,
	output logic                               run_end
);
	import ldapesc_pkg::*;

	q_entry_t  front_entry;
	q_entry_t  head;
	q_status_t status;
	logic      accept;
	logic      pop;

	// classify the byte on the command side as it arrives
	ldapesc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.final_byte (final_byte),
		.entry      (front_entry)
	);

	// hold off new items only while the queue is full
	assign busy   = status.full;
	assign accept = start && !busy;

	// decouple the two sides: the sequencer drains while the front keeps taking items
	ldapesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_entry (front_entry),
		.pop        (pop),
		.head       (head),
		.status     (status)
	);

	// emit one result per cycle while work is pending, from the queue head or the held byte
	ldapesc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.status   (status),
		.pop      (pop),
		.strobe   (strobe),
		.out_byte (out_byte),
		.run_end  (run_end)
	);

endmodule

/* sim/tb_ldap_string_escaper.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ldap_string_escaper - self-checking bench for the LDAP byte escaper
// Feeds strings byte by byte through the command port, predicts every output
// character (raw byte, or backslash plus two lower-case hex digits) from its
// own copy of the mode and ignore-mask registers, and compares each strobed
// result in order. Runs a directed set, then random strings over several
// register settings with varying sender gaps.
// ----------------------------------------------------------------------------
module tb_ldap_string_escaper;
	import ldapesc_pkg::*;

	localparam int SETTLE_CYCLES    = 4;    // idle cycles after the last owed result
	localparam int IDLE_LIMIT       = 1000; // cycles with no item and no result
	localparam int ITEMS_PER_SETUP  = 47;
	localparam int SETUPS_PER_PHASE = 3;

	// indexes past the register file; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

	// mask flavors for the random settings
	localparam int MASK_CLEAR  = 0;
	localparam int MASK_FULL   = 1;
	localparam int MASK_SPARSE = 2;
	localparam int MASK_DENSE  = 3;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} out_char_t;

	// Escaped-text predictor: keeps a shadow of the registers and the queue of
	// characters the block still owes us.
	class escaped_text_board;
		logic [1:0]  mode;
		logic [63:0] ignore_mask [4];
		out_char_t   owed_chars [$];
		string       hex_text;
		int          items;
		int          escaped_items;
		int          chars_seen;
		int          failures;

		function new();
			mode = 2'd0;
			for (int w = 0; w < 4; w++) begin
				ignore_mask[w] = 64'd0;
			end
			hex_text = "0123456789abcdef";
			items = 0;
			escaped_items = 0;
			chars_seen = 0;
			failures = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
			case (idx)
				CFG_ESCAPE_MODE:    mode = val[1:0];
				CFG_IGNORE_MASK_LO: ignore_mask[0] = val;
				CFG_IGNORE_MASK_ML: ignore_mask[1] = val;
				CFG_IGNORE_MASK_MH: ignore_mask[2] = val;
				CFG_IGNORE_MASK_HI: ignore_mask[3] = val;
				default: ;
			endcase
		endfunction

		function bit needs_escape(input logic [7:0] c, input logic f, input logic l);
			bit filt;
			bit dn;
			bit esc;
			filt = (mode == 2'd0) || mode[0];
			dn   = (mode == 2'd0) || mode[1];
			esc  = 1'b0;
			// NUL is escaped whatever the mask says
			if (c == CH_NUL) begin
				return 1'b1;
			end
			if (filt && (c == CH_STAR || c == CH_LPAR || c == CH_RPAR || c == CH_BSL)) begin
				esc = 1'b1;
			end
			if (dn && (c == CH_BSL || c == CH_COMMA || c == CH_PLUS || c == CH_QUOTE ||
			           c == CH_LT || c == CH_GT || c == CH_SEMI)) begin
				esc = 1'b1;
			end
			if (dn && f && (c == CH_SPACE || c == CH_HASH)) begin
				esc = 1'b1;
			end
			if (dn && l && c == CH_SPACE) begin
				esc = 1'b1;
			end
			if (ignore_mask[c[7:6]][c[5:0]]) begin
				esc = 1'b0;
			end
			return esc;
		endfunction

		// append one character to the owed list
		function void owe(input logic [7:0] ch, input logic last);
			out_char_t next_char;
			next_char.ch   = ch;
			next_char.last = last;
			owed_chars = {owed_chars, next_char};
		endfunction

		// note an accepted byte and queue the characters it must produce
		function void take_byte(input logic [7:0] c, input logic f, input logic l);
			items++;
			if (needs_escape(c, f, l)) begin
				escaped_items++;
				owe(CH_BSL, 1'b0);
				owe(8'(hex_text[c[7:4]]), 1'b0);
				owe(8'(hex_text[c[3:0]]), 1'b1);
			end else begin
				owe(c, 1'b1);
			end
		endfunction

		// compare one strobed character with the oldest one owed
		function void match_char(input logic [7:0] ch, input logic last);
			out_char_t want;
			if (owed_chars.size() == 0) begin
				failures++;
				$display("%0t: unexpected result out_byte=%h run_end=%b", $time, ch, last);
				return;
			end
			want = owed_chars.pop_front();
			chars_seen++;
			if (ch !== want.ch) begin
				failures++;
				$display("%0t: out_byte expected %h got %h", $time, want.ch, ch);
			end
			if (last !== want.last) begin
				failures++;
				$display("%0t: run_end expected %b got %b", $time, want.last, last);
			end
		endfunction

		function int owed();
			return owed_chars.size();
		endfunction
	endclass

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  wr_en      = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index   = '0;
	logic [CFG_DATA_W-1:0] wr_data    = '0;
	logic                  start      = 1'b0;
	logic                  busy;
	logic [7:0]            data_byte  = 8'd0;
	logic                  first_byte = 1'b0;
	logic                  final_byte = 1'b0;
	logic                  strobe;
	logic [7:0]            out_byte;
	logic                  run_end;

	escaped_text_board text_board;
	int                idle_cycles = 0;
	int                setups_done = 0;

	ldap_string_escaper dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.start      (start),
		.busy       (busy),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.final_byte (final_byte),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.run_end    (run_end)
	);

	always #10 clk = ~clk;

	// Monitor: inputs are driven with NBAs at the edge, so at the edge this block
	// sees the values that the DUT samples there.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			text_board.take_byte(data_byte, first_byte, final_byte);
		end
		if (arst_n && strobe) begin
			text_board.match_char(out_byte, run_end);
		end
	end

	// Watchdog: any accepted item or result restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results owed", $time,
				IDLE_LIMIT, text_board.owed());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one byte and hold it until the block takes it. Leave start high when
	// no gap follows so back-to-back items never toggle start within one step.
	// Each following cycle idles with a chance of gap_pct percent.
	task automatic push_byte(input logic [7:0] b, input logic f, input logic l,
	                         input int gap_pct);
		start      <= 1'b1;
		data_byte  <= b;
		first_byte <= f;
		final_byte <= l;
		do @(posedge clk); while (busy);
		if ($urandom_range(0, 99) < gap_pct) begin
			// idle with junk on the payload lines
			start      <= 1'b0;
			data_byte  <= 8'($urandom);
			first_byte <= 1'($urandom);
			final_byte <= 1'($urandom);
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
	endtask

	// Drop start and wait until every owed character has come out, then let the
	// pipeline run dry.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (text_board.owed() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller lowers wr_en after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		text_board.set_reg(idx, val);
	endtask

	task automatic load_settings(input logic [63:0] mode_word, input logic [63:0] lo,
	                             input logic [63:0] ml, input logic [63:0] mh,
	                             input logic [63:0] hi);
		write_reg(CFG_ESCAPE_MODE, mode_word);
		write_reg(CFG_IGNORE_MASK_LO, lo);
		write_reg(CFG_IGNORE_MASK_ML, ml);
		write_reg(CFG_IGNORE_MASK_MH, mh);
		write_reg(CFG_IGNORE_MASK_HI, hi);
		wr_en <= 1'b0;
		setups_done++;
	endtask

	function automatic logic [63:0] rand64();
		return {32'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [63:0] make_mask(input int kind);
		case (kind)
			MASK_CLEAR:  return 64'd0;
			MASK_FULL:   return '1;
			MASK_SPARSE: return rand64() & rand64() & rand64();
			default:     return rand64();
		endcase
	endfunction

	// Lean on the characters that matter; a trailing space is favored at the end.
	function automatic logic [7:0] pick_char(input bit at_end);
		int sel;
		sel = $urandom_range(0, 23);
		if (at_end && sel < 3) begin
			return CH_SPACE;
		end
		case (sel)
			0:  return CH_STAR;
			1:  return CH_LPAR;
			2:  return CH_RPAR;
			3:  return CH_BSL;
			4:  return CH_COMMA;
			5:  return CH_PLUS;
			6:  return CH_QUOTE;
			7:  return CH_LT;
			8:  return CH_GT;
			9:  return CH_SEMI;
			10: return CH_SPACE;
			11: return CH_HASH;
			12: return CH_NUL;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Send one string of 1..8 bytes. Most carry proper first/final marks; a few
	// get random marks to exercise unordered or missing boundaries.
	task automatic send_string(input int gap_pct, inout int sent);
		int len;
		int i;
		bit broken;
		logic f;
		logic l;
		len    = $urandom_range(1, 8);
		broken = ($urandom_range(0, 99) < 15);
		for (i = 0; i < len; i++) begin
			f = broken ? 1'($urandom) : (i == 0);
			l = broken ? 1'($urandom) : (i == len - 1);
			push_byte(pick_char(i == len - 1), f, l, gap_pct);
		end
		sent += len;
	endtask

	initial begin
		int gap_pct;
		int sent;
		int k;
		int kind;
		text_board = new();

		// hold reset, then release it on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values give both escapings and an empty ignore mask.
		push_byte(CH_NUL,   1'b1, 1'b0, 0);
		push_byte(8'hff,    1'b0, 1'b0, 0);
		push_byte(CH_STAR,  1'b0, 1'b0, 0);
		push_byte(CH_LPAR,  1'b0, 1'b0, 0);
		push_byte(CH_RPAR,  1'b0, 1'b0, 0);
		push_byte(CH_BSL,   1'b0, 1'b0, 0);
		push_byte(CH_COMMA, 1'b0, 1'b0, 0);
		push_byte(CH_PLUS,  1'b0, 1'b0, 0);
		push_byte(CH_QUOTE, 1'b0, 1'b0, 0);
		push_byte(CH_LT,    1'b0, 1'b0, 0);
		push_byte(CH_GT,    1'b0, 1'b0, 0);
		push_byte(CH_SEMI,  1'b0, 1'b0, 0);
		// leading space and hash, trailing space, and the same bytes elsewhere
		push_byte(CH_SPACE, 1'b1, 1'b0, 0);
		push_byte(CH_HASH,  1'b1, 1'b0, 0);
		push_byte(CH_SPACE, 1'b0, 1'b1, 0);
		push_byte(CH_HASH,  1'b0, 1'b1, 0);
		push_byte(CH_SPACE, 1'b0, 1'b0, 0);
		// single-byte strings: first and final rules at once
		push_byte(CH_SPACE, 1'b1, 1'b1, 0);
		push_byte(CH_HASH,  1'b1, 1'b1, 0);
		settle();

		// All ones everywhere: mode clips to both bits, every byte but NUL passes.
		// Then write past the register file; nothing may change.
		load_settings('1, '1, '1, '1, '1);
		@(posedge clk);
		write_reg(CFG_UNUSED_LO, 64'd0);
		write_reg(CFG_UNUSED_HI, 64'd0);
		wr_en <= 1'b0;
		push_byte(CH_NUL,   1'b1, 1'b1, 0);
		push_byte(CH_BSL,   1'b0, 1'b0, 0);
		push_byte(CH_SPACE, 1'b1, 1'b1, 0);
		push_byte(8'h80,    1'b0, 1'b0, 0);
		settle();

		// Random strings: sender gaps of 21 %, then 58 %, then none. Each phase
		// walks through several register settings, draining before each change.
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 21 : (phase == 1) ? 58 : 0;
			for (int s = 0; s < SETUPS_PER_PHASE; s++) begin
				k = phase * SETUPS_PER_PHASE + s;
				case (k)
					0, 5:    kind = MASK_CLEAR;
					2, 7:    kind = MASK_FULL;
					1, 6:    kind = MASK_SPARSE;
					default: kind = MASK_DENSE;
				endcase
				// junk in the upper mode bits must be dropped
				load_settings((rand64() & ~64'd3) | 64'(k % 4), make_mask(kind),
					make_mask(kind), make_mask(kind), make_mask(kind));
				sent = 0;
				while (sent < ITEMS_PER_SETUP) begin
					send_string(gap_pct, sent);
				end
				settle();
			end
		end

		$display("Sent %0d bytes (%0d escaped) over %0d register settings,",
			text_board.items, text_board.escaped_items, setups_done + 1);
		$display("checked %0d output characters in order, %0d mismatches.",
			text_board.chars_seen, text_board.failures);
		if (text_board.failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* ldap_string_escaper.f */
rtl/core/ldapesc_pkg.sv
rtl/core/ldapesc_front.sv
rtl/core/ldapesc_queue.sv
rtl/core/ldapesc_back.sv
rtl/core/ldap_string_escaper.sv
sim/tb_ldap_string_escaper.sv
